[src/bicubic_image_scaler_u8_core_macros.svh]
// Assertion helpers for the scaler RTL
`ifndef BICUBIC_IMAGE_SCALER_U8_CORE_MACROS_SVH
`define BICUBIC_IMAGE_SCALER_U8_CORE_MACROS_SVH

// Property checked outside reset
`define BISC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every edge, reset included
`define BISC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/bisc_pkg.sv]
package bisc_pkg;

  // Frame store geometry and fixed point
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int FRAC_BITS   = 12;
  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // Field and register widths
  localparam int COORD_W    = 12;
  localparam int DIM_W      = 9;
  localparam int STEP_W     = 21;
  localparam int PIX_W      = 8;
  localparam int STAT_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  // Arithmetic unit widths
  localparam int ACC_W      = 32;
  localparam int OPA_W      = 33;
  localparam int PROD_W     = 2 * OPA_W;
  localparam int QUOT_SHIFT = 33;
  localparam int QUOT_W     = 29;

  // Divide by three: offset keeps the dividend positive, reciprocal is ceil(2^33/3)
  localparam logic signed [OPA_W-1:0] DIV_RECIP = 33'sh0AAAAAAAB;
  localparam logic signed [ACC_W-1:0] DIV_OFS   = 32'sh3000_0000;
  localparam logic signed [ACC_W-1:0] DIV_BIAS  = 32'sh1000_0000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 2'd3;

  // Request and status codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_COMPUTE = 1'b1;
  localparam logic [STAT_W-1:0] ST_LOADED  = 2'd0;
  localparam logic [STAT_W-1:0] ST_PIXEL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_IGNORED = 2'd2;

  // Arithmetic unit operations
  localparam logic [2:0] ALU_NOP = 3'd0;
  localparam logic [2:0] ALU_POS = 3'd1;
  localparam logic [2:0] ALU_C3  = 3'd2;
  localparam logic [2:0] ALU_C2  = 3'd3;
  localparam logic [2:0] ALU_C1  = 3'd4;
  localparam logic [2:0] ALU_DIV = 3'd5;

  typedef logic signed [ACC_W-1:0] acc_t;

  typedef struct packed {
    logic [2:0] op;
    logic       vert;
  } alu_ctrl_t;

endpackage

[src/bisc_ram.sv]
module bisc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/bisc_alu.sv]
module bisc_alu import bisc_pkg::*; (
  input  logic                 clk,
  input  alu_ctrl_t            ctrl,
  input  acc_t                 opnd [4],
  input  logic [FRAC_BITS-1:0] t,
  input  logic [COORD_W-1:0]   pos_a,
  input  logic [STEP_W-1:0]    pos_b,
  output logic [PROD_W-1:0]    prod,
  output acc_t                 quot
);

  acc_t d0, d2, d3, c1, c2, c3, six_p0, prev, s, m;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [OPA_W-1:0]  a, b;

  // Cubic coefficients, all scaled by six
  always_comb begin
    d0     = opnd[0] - opnd[1];
    d2     = opnd[2] - opnd[1];
    d3     = opnd[3] - opnd[1];
    c1     = (d2 <<< 2) + (d2 <<< 1) - (d0 <<< 1) - d3;
    c2     = (d0 <<< 1) + d0 + (d2 <<< 1) + d2;
    c3     = d3 - d0 - (d2 <<< 1) - d2;
    six_p0 = (opnd[1] <<< 2) + (opnd[1] <<< 1);
  end

  // Previous product back to the accumulator scale, floor rounding
  assign prod_sh = $signed(prod) >>> FRAC_BITS;
  assign prev    = prod_sh[ACC_W-1:0];

  // Operand selection for the shared multiplier
  always_comb begin
    s = prev + six_p0;
    m = ctrl.vert ? (s >>> (FRAC_BITS + 1)) : (s >>> 1);
    a = '0;
    b = $signed({{(OPA_W-FRAC_BITS){1'b0}}, t});
    case (ctrl.op)
      ALU_POS: begin
        a = $signed({{(OPA_W-COORD_W){1'b0}}, pos_a});
        b = $signed({{(OPA_W-STEP_W){1'b0}}, pos_b});
      end
      ALU_C3: a = $signed({c3[ACC_W-1], c3});
      ALU_C2: begin
        s = prev + c2;
        a = $signed({s[ACC_W-1], s});
      end
      ALU_C1: begin
        s = prev + c1;
        a = $signed({s[ACC_W-1], s});
      end
      ALU_DIV: begin
        a = $signed({1'b0, m + DIV_OFS});
        b = DIV_RECIP;
      end
      default: begin
        a = '0;
        b = '0;
      end
    endcase
  end

  // Product register
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Floor quotient after the reciprocal multiply
  assign quot = acc_t'({{(ACC_W-QUOT_W){1'b0}}, prod[QUOT_SHIFT+QUOT_W-1:QUOT_SHIFT]})
                - DIV_BIAS;

endmodule

[src/bicubic_image_scaler_u8_core.sv]
// Grayscale bicubic scaler. A load transaction (req_type 0) writes one source byte into a
// 256x256 frame store and returns status 0, or status 2 when col/row lie outside the
// programmed source size; its result is registered from the S_DONE state, after which the
// block returns to idle and can accept the next transaction. A compute transaction
// (req_type 1) maps the destination col/row through x_step/y_step (12 fraction bits),
// reads the 4x4 neighbourhood (edges clamped), filters horizontally then vertically and
// returns a saturated byte with status 1. It performs two position multiplies, 16 frame
// store reads through the one read port and four multiply steps per cubic (five cubics),
// all on one shared multiplier, before its result is registered. A stalled result holds
// the block until it is taken. One transaction is in flight at a time; load the whole
// source before computing, and write the registers only while idle.
`include "bicubic_image_scaler_u8_core_macros.svh"

module bicubic_image_scaler_u8_core import bisc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  req_type,
  input  logic [COORD_W-1:0]    col,
  input  logic [COORD_W-1:0]    row,
  input  logic [PIX_W-1:0]      pixel_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIX_W-1:0]      pixel_out,
  output logic [STAT_W-1:0]     status
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MX   = 4'd1;
  localparam logic [3:0] S_MY   = 4'd2;
  localparam logic [3:0] S_MYW  = 4'd3;
  localparam logic [3:0] S_RD   = 4'd4;
  localparam logic [3:0] S_RDW  = 4'd5;
  localparam logic [3:0] S_H1   = 4'd6;
  localparam logic [3:0] S_H2   = 4'd7;
  localparam logic [3:0] S_H3   = 4'd8;
  localparam logic [3:0] S_H4   = 4'd9;
  localparam logic [3:0] S_H5   = 4'd10;
  localparam logic [3:0] S_DONE = 4'd11;

  logic [3:0]            state;
  logic [1:0]            jj, ii, rd_idx;
  logic                  vert, rd_pend;
  logic [DIM_W-1:0]      img_w, img_h, eff_w, eff_h;
  logic [STEP_W-1:0]     x_step, y_step;
  logic [COORD_W-1:0]    col_r, row_r;
  logic [DIM_W-1:0]      xi, yi, rc, cc;
  logic [FRAC_BITS-1:0]  dx, dy;
  logic [STEP_W-1:0]     pos_int;
  acc_t                  p [4];
  acc_t                  hv [4];
  acc_t                  opnd [4];
  acc_t                  quot;
  logic [PROD_W-1:0]     prod;
  logic [PIX_W-1:0]      res_pix, rdata;
  logic [STAT_W-1:0]     res_stat;
  logic                  accept, load_in, out_free, ram_we;
  logic [ADDR_W-1:0]     waddr, raddr;
  alu_ctrl_t             alu_ctrl;

  // Neighbour index clamped to 0..size-1
  function automatic logic [DIM_W-1:0] clamp_idx(input logic [DIM_W-1:0] base,
                                                  input logic [1:0] k,
                                                  input logic [DIM_W-1:0] sz);
    logic signed [DIM_W+1:0] v;
    logic signed [DIM_W+1:0] hi;
    v  = $signed({2'b00, base}) + $signed({{DIM_W{1'b0}}, k}) - $signed((DIM_W+2)'(1));
    hi = $signed({2'b00, sz}) - $signed((DIM_W+2)'(1));
    if (v < 0) begin
      return '0;
    end
    if (v > hi) begin
      return hi[DIM_W-1:0];
    end
    return v[DIM_W-1:0];
  endfunction

  // Effective source size
  always_comb begin
    eff_w = img_w;
    if (img_w == '0) eff_w = DIM_W'(1);
    else if (int'(img_w) > MAX_WIDTH) eff_w = DIM_W'(MAX_WIDTH);
    eff_h = img_h;
    if (img_h == '0) eff_h = DIM_W'(1);
    else if (int'(img_h) > MAX_HEIGHT) eff_h = DIM_W'(MAX_HEIGHT);
  end

  // Handshake and store write
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_in  = (col < COORD_W'(eff_w)) && (row < COORD_W'(eff_h));
  assign ram_we   = accept && (req_type == REQ_LOAD) && load_in;
  assign waddr    = ADDR_W'(int'(row) * MAX_WIDTH + int'(col));
  assign out_free = !out_valid || !out_stall;

  // Neighbourhood read address
  assign rc    = clamp_idx(yi, jj, eff_h);
  assign cc    = clamp_idx(xi, ii, eff_w);
  assign raddr = ADDR_W'(int'(rc) * MAX_WIDTH + int'(cc));

  bisc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (pixel_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Arithmetic unit control
  always_comb begin
    alu_ctrl.vert = vert;
    unique case (state)
      S_MX, S_MY: alu_ctrl.op = ALU_POS;
      S_H1:       alu_ctrl.op = ALU_C3;
      S_H2:       alu_ctrl.op = ALU_C2;
      S_H3:       alu_ctrl.op = ALU_C1;
      S_H4:       alu_ctrl.op = ALU_DIV;
      default:    alu_ctrl.op = ALU_NOP;
    endcase
    for (int k = 0; k < 4; k++) begin
      opnd[k] = vert ? hv[k] : p[k];
    end
  end

  bisc_alu u_alu (
    .clk   (clk),
    .ctrl  (alu_ctrl),
    .opnd  (opnd),
    .t     (vert ? dy : dx),
    .pos_a ((state == S_MX) ? col_r : row_r),
    .pos_b ((state == S_MX) ? x_step : y_step),
    .prod  (prod),
    .quot  (quot)
  );

  assign pos_int = prod[COORD_W+STEP_W-1:FRAC_BITS];

  // Sequencer, registers and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      jj        <= '0;
      ii        <= '0;
      vert      <= 1'b0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      img_w     <= DIM_W'(256);
      img_h     <= DIM_W'(256);
      x_step    <= STEP_W'(4096);
      y_step    <= STEP_W'(4096);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SRC_WIDTH:  img_w  <= cfg_data[DIM_W-1:0];
          REG_SRC_HEIGHT: img_h  <= cfg_data[DIM_W-1:0];
          REG_X_STEP:     x_step <= cfg_data[STEP_W-1:0];
          REG_Y_STEP:     y_step <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end
      rd_pend <= (state == S_RD);
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            jj    <= '0;
            ii    <= '0;
            vert  <= 1'b0;
            state <= (req_type == REQ_LOAD) ? S_DONE : S_MX;
          end
        end
        S_MX:  state <= S_MY;
        S_MY:  state <= S_MYW;
        S_MYW: state <= S_RD;
        S_RD: begin
          ii <= ii + 2'd1;
          if (ii == 2'd3) state <= S_RDW;
        end
        S_RDW: state <= S_H1;
        S_H1:  state <= S_H2;
        S_H2:  state <= S_H3;
        S_H3:  state <= S_H4;
        S_H4:  state <= S_H5;
        S_H5: begin
          if (vert) begin
            state <= S_DONE;
          end else if (jj == 2'd3) begin
            vert  <= 1'b1;
            state <= S_H1;
          end else begin
            jj    <= jj + 2'd1;
            ii    <= '0;
            state <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath payload registers
  always_ff @(posedge clk) begin
    rd_idx <= ii;
    if (accept) begin
      col_r <= col;
      row_r <= row;
      res_pix <= '0;
      res_stat <= load_in ? ST_LOADED : ST_IGNORED;
    end
    if (state == S_MY) begin
      xi <= (pos_int > STEP_W'(eff_w)) ? eff_w : pos_int[DIM_W-1:0];
      dx <= prod[FRAC_BITS-1:0];
    end
    if (state == S_MYW) begin
      yi <= (pos_int > STEP_W'(eff_h)) ? eff_h : pos_int[DIM_W-1:0];
      dy <= prod[FRAC_BITS-1:0];
    end
    if (rd_pend) begin
      p[rd_idx] <= acc_t'({{(ACC_W-PIX_W-FRAC_BITS){1'b0}}, rdata, {FRAC_BITS{1'b0}}});
    end
    if (state == S_H5) begin
      if (!vert) begin
        hv[jj] <= quot;
      end else begin
        res_stat <= ST_PIXEL;
        if (quot < 0) res_pix <= '0;
        else if (quot > acc_t'(255)) res_pix <= '1;
        else res_pix <= quot[PIX_W-1:0];
      end
    end
    if (state == S_DONE && out_free) begin
      pixel_out <= res_pix;
      status    <= res_stat;
    end
  end

  // Checks
  `BISC_ASSERT_ALWAYS(a_rst_clears_out, rst |=> !out_valid, "output valid after reset")
  `BISC_ASSERT(a_load_zero_pixel, (out_valid && status != ST_PIXEL) |-> (pixel_out == '0), "load result carries a nonzero pixel")
  `BISC_ASSERT(a_compute_starts, (accept && req_type == REQ_COMPUTE) |=> (state == S_MX), "compute did not start")
  `BISC_ASSERT(a_filter_entry, (state == S_H1) |-> ($past(state) == S_RDW || $past(state) == S_H5), "filter entered out of order")

endmodule
